### hw/rtl/tia_pkg.sv
// Shared types, codes and widths for the tag ID access table.
package tia_pkg;

  // Default configuration
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned ID_BYTES_DEF    = 8;

  // Field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned TAG_W     = 64;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned OCC_OUT_W = 5;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 16;
  localparam int unsigned M_PAD_W   = M_TDATA_W - SLOT_W - OCC_OUT_W;

  // Operation codes
  localparam logic [OP_W-1:0] OP_AUTH = 2'd0;
  localparam logic [OP_W-1:0] OP_EDIT = 2'd1;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_MEMBER     = 3'd0,
    ST_NOT_MEMBER = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_ADDED      = 3'd3,
    ST_REMOVED    = 3'd4,
    ST_FULL       = 3'd5,
    ST_SIZE_ERR   = 3'd6,
    ST_MODE_ERR   = 3'd7
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input item, restart the scan
    logic rd_en;   // read the next table entry
    logic commit;  // apply the table update and load the result
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // read address is at the last entry
  } dp_stat_t;

endpackage

### hw/rtl/tia_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tia_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tia_ctrl.sv
// Sequencing state machine: accept, scan the table, commit, hand off the result.
module tia_ctrl import tia_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new item this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Commands
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.rd_en  = (state_q == S_SCAN);
    cmd_o.commit = (state_q == S_COMMIT) && out_free;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/tia_dpath.sv
// Table storage, entry scan, match and free-slot tracking, update and result registers.
module tia_dpath import tia_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned ID_BYTES    = ID_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_cmd_t             cmd_i,
  output dp_stat_t             stat_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [TAG_W-1:0]     tag_id_i,
  input  logic [LEN_W-1:0]     tag_len_i,
  input  logic [LEN_W-1:0]     read_len_i,
  output status_e              status_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic [OCC_OUT_W-1:0] occupied_o
);

  localparam int unsigned ID_BITS = 8 * ID_BYTES;
  localparam int unsigned IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OCC_W   = $clog2(MAX_ENTRIES + 1);

  // Item registers
  logic [OP_W-1:0]    op_q;
  logic [ID_BITS-1:0] tag_q;
  logic [ID_BITS-1:0] mask_q;
  logic               size_err_q;
  logic [ID_BITS-1:0] mask_in;

  // Scan registers
  logic [IDX_W-1:0]   addr_q;
  logic               cmp_vld_q;
  logic [IDX_W-1:0]   cmp_idx_q;
  logic               found_q;
  logic [IDX_W-1:0]   hit_q;
  logic               free_found_q;
  logic [IDX_W-1:0]   free_q;

  // Table state: an entry whose used flag is clear reads as zero
  logic [MAX_ENTRIES-1:0] used_q, used_d;
  logic [OCC_W-1:0]       occ_q, occ_d;
  logic [ID_BITS-1:0]     rdata;
  logic [ID_BITS-1:0]     entry;
  logic                   hit_now;
  logic                   free_now;
  logic                   we;

  // Result registers
  status_e               status_q, status_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [OCC_OUT_W-1:0]  occ_out_q;

  // Byte mask of the compared length, limited to the stored bytes
  always_comb begin
    mask_in = '0;
    for (int b = 0; b < ID_BYTES; b++) begin
      mask_in[8*b +: 8] = {8{tag_len_i > LEN_W'(b)}};
    end
  end

  tia_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(free_q),
    .wdata_i(tag_q),
    .re_i   (cmd_i.rd_en),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  assign stat_o.scan_last = (addr_q == IDX_W'(MAX_ENTRIES - 1));

  // Compare the entry read in the previous cycle
  assign entry    = used_q[cmp_idx_q] ? rdata : '0;
  assign hit_now  = ((entry ^ tag_q) & mask_q) == '0;
  assign free_now = !used_q[cmp_idx_q];

  // Decision and table update
  always_comb begin
    status_d = ST_MODE_ERR;
    slot_d   = '0;
    used_d   = used_q;
    occ_d    = occ_q;
    we       = 1'b0;
    if (size_err_q) begin
      status_d = ST_SIZE_ERR;
    end else begin
      unique case (op_q)
        OP_AUTH: begin
          if (occ_q == '0) begin
            status_d = ST_EMPTY;
          end else if (found_q) begin
            status_d = ST_MEMBER;
            slot_d   = SLOT_W'(hit_q);
          end else begin
            status_d = ST_NOT_MEMBER;
          end
        end
        OP_EDIT: begin
          if (occ_q != '0 && found_q) begin
            status_d       = ST_REMOVED;
            slot_d         = SLOT_W'(hit_q);
            used_d[hit_q]  = 1'b0;
            if (used_q[hit_q]) begin
              occ_d = occ_q - OCC_W'(1);
            end
          end else if (occ_q == OCC_W'(MAX_ENTRIES)) begin
            status_d = ST_FULL;
          end else begin
            status_d       = ST_ADDED;
            slot_d         = SLOT_W'(free_q);
            we             = cmd_i.commit;
            used_d[free_q] = |tag_q;
            if (|tag_q) begin
              occ_d = occ_q + OCC_W'(1);
            end
          end
        end
        default: begin
          status_d = ST_MODE_ERR;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      occ_q        <= '0;
      cmp_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.rd_en;
      if (cmd_i.load) begin
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmp_vld_q) begin
        if (hit_now && !found_q) begin
          found_q <= 1'b1;
        end
        if (free_now && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        used_q <= used_d;
        occ_q  <= occ_d;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= op_i;
      tag_q      <= tag_id_i[ID_BITS-1:0] & mask_in;
      mask_q     <= mask_in;
      size_err_q <= read_len_i < tag_len_i;
      addr_q     <= '0;
    end else if (cmd_i.rd_en) begin
      addr_q <= addr_q + IDX_W'(1);
    end
    cmp_idx_q <= addr_q;
    if (cmp_vld_q) begin
      if (hit_now && !found_q) begin
        hit_q <= cmp_idx_q;
      end
      if (free_now && !free_found_q) begin
        free_q <= cmp_idx_q;
      end
    end
    if (cmd_i.commit) begin
      status_q  <= status_d;
      slot_q    <= slot_d;
      occ_out_q <= OCC_OUT_W'(occ_d);
    end
  end

  assign status_o   = status_q;
  assign slot_o     = slot_q;
  assign occupied_o = occ_out_q;

endmodule

### hw/rtl/tag_id_access_table.sv
// Top level of the tag ID access table: stream ports, controller and datapath.
//
// Keeps MAX_ENTRIES tag IDs of ID_BYTES bytes; each item authenticates a tag
// or toggles it in the table, and gives one result item with a status, the
// slot involved and the occupancy after the step. The table reads as empty
// right after reset (per-entry used flags, no clearing pass). A new item is
// accepted only after the previous one has gone through the accept, a scan
// of every table entry through the single read port of the table RAM, the
// last compare and the commit. The result sits in an output register, so the
// next item is accepted while it waits to be taken; the commit of that next
// item waits until the earlier result has been taken.
module tag_id_access_table import tia_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned ID_BYTES    = ID_BYTES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // tag_id[63:0], tag_len[67:64], read_len[71:68]
  input  logic [OP_W-1:0]      s_axis_tuser_i,  // op[1:0]
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // slot[3:0], occupied[8:4], zero[15:9]
  output logic [STATUS_W-1:0]  m_axis_tuser_o   // status[2:0]
);

  ctl_cmd_t              cmd;
  dp_stat_t              stat;
  status_e               status;
  logic [SLOT_W-1:0]     slot;
  logic [OCC_OUT_W-1:0]  occupied;

  tia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tia_dpath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .ID_BYTES   (ID_BYTES)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .op_i      (s_axis_tuser_i),
    .tag_id_i  (s_axis_tdata_i[TAG_W-1:0]),
    .tag_len_i (s_axis_tdata_i[TAG_W +: LEN_W]),
    .read_len_i(s_axis_tdata_i[TAG_W+LEN_W +: LEN_W]),
    .status_o  (status),
    .slot_o    (slot),
    .occupied_o(occupied)
  );

  // Result packing
  assign m_axis_tdata_o = {M_PAD_W'(0), occupied, slot};
  assign m_axis_tuser_o = status;

endmodule
